// ===== hdl/spq_pkg.sv =====
package spq_pkg;

  localparam int unsigned CAPACITY_DEF     = 16;
  localparam int unsigned KEY_BITS_DEF     = 16;
  localparam int unsigned PAYLOAD_BITS_DEF = 32;

  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_POP  = 1'b1;

  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctrl_t;

endpackage

// ===== hdl/sorted_priority_queue.sv =====
// Min-first priority queue held as a row of CAPACITY cells in ascending key order,
// cell 0 being the head. Each input word is a push (in_tuser low) or a pop (in_tuser
// high) and returns exactly one status word. A push is placed ahead of every stored
// entry with a key greater than or equal to its own; a push into a full queue is
// dropped and flagged, and a pop of an empty queue returns zeros. All cells compare
// the new key at once and shift by one position in the same cycle, so one word is
// taken every clock while the output register is not stalled; the result is captured
// there, and a new word is taken whenever that register is empty or being read.
module sorted_priority_queue #(
  parameter int unsigned CAPACITY     = spq_pkg::CAPACITY_DEF,
  parameter int unsigned KEY_BITS     = spq_pkg::KEY_BITS_DEF,
  parameter int unsigned PAYLOAD_BITS = spq_pkg::PAYLOAD_BITS_DEF,
  parameter int unsigned IN_W         = ((KEY_BITS + PAYLOAD_BITS + 7) / 8) * 8,
  parameter int unsigned OUT_W        = ((KEY_BITS + PAYLOAD_BITS + 3 + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // key, payload
  input  logic             in_tuser,   // func
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata,  // out_key, out_payload, dropped, is_empty, is_full
  output logic             out_tuser   // pop_valid
);
  import spq_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic [CW-1:0]           count_r, count_nxt, count_after;
  logic                    full, empty, accept, is_pop;
  logic                    res_pop_valid, res_dropped;
  logic [KEY_BITS-1:0]     in_key, res_key;
  logic [PAYLOAD_BITS-1:0] in_payload, res_payload;
  cell_ctrl_t              ctrl;

  logic                    out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]        out_data_r;
  logic                    out_user_r;

  logic                    ins     [CAPACITY];
  logic [KEY_BITS-1:0]     keys    [CAPACITY];
  logic [PAYLOAD_BITS-1:0] pays    [CAPACITY];

  assign in_key     = in_tdata[KEY_BITS-1:0];
  assign in_payload = in_tdata[KEY_BITS+PAYLOAD_BITS-1:KEY_BITS];
  assign is_pop     = (in_tuser == FUNC_POP);

  assign full      = (count_r == CW'(CAPACITY));
  assign empty     = (count_r == '0);
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  assign ctrl = '{push: accept && !is_pop && !full, pop: accept && is_pop && !empty};

  always_comb begin
    count_after = count_r;
    if (!is_pop && !full) count_after = count_r + CW'(1);
    else if (is_pop && !empty) count_after = count_r - CW'(1);
  end

  assign count_nxt     = accept ? count_after : count_r;
  assign res_pop_valid = is_pop && !empty;
  assign res_dropped   = !is_pop && full;
  assign res_key       = res_pop_valid ? keys[0] : '0;
  assign res_payload   = res_pop_valid ? pays[0] : '0;

  generate
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                    l_ins;
      logic [KEY_BITS-1:0]     l_key, r_key;
      logic [PAYLOAD_BITS-1:0] l_pay, r_pay;
      if (i == 0) begin : g_first
        assign l_ins = 1'b0;
        assign l_key = in_key;
        assign l_pay = in_payload;
      end else begin : g_mid
        assign l_ins = ins[i-1];
        assign l_key = keys[i-1];
        assign l_pay = pays[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
        assign r_key = keys[i];
        assign r_pay = pays[i];
      end else begin : g_inner
        assign r_key = keys[i+1];
        assign r_pay = pays[i+1];
      end
      spq_cell #(
        .KEY_BITS     (KEY_BITS),
        .PAYLOAD_BITS (PAYLOAD_BITS)
      ) u_cell (
        .clk           (clk),
        .ctrl          (ctrl),
        .occupied      (CW'(i) < count_r),
        .new_key       (in_key),
        .new_payload   (in_payload),
        .left_ins      (l_ins),
        .left_key      (l_key),
        .left_payload  (l_pay),
        .right_key     (r_key),
        .right_payload (r_pay),
        .ins           (ins[i]),
        .key_r         (keys[i]),
        .payload_r     (pays[i])
      );
    end
  endgenerate

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_user_r <= res_pop_valid;
      out_data_r <= OUT_W'({(count_after == CW'(CAPACITY)), (count_after == '0),
                            res_dropped, res_payload, res_key});
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

// ===== hdl/spq_cell.sv =====
module spq_cell #(
  parameter int unsigned KEY_BITS     = spq_pkg::KEY_BITS_DEF,
  parameter int unsigned PAYLOAD_BITS = spq_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                    clk,
  input  spq_pkg::cell_ctrl_t     ctrl,
  input  logic                    occupied,
  input  logic [KEY_BITS-1:0]     new_key,
  input  logic [PAYLOAD_BITS-1:0] new_payload,
  input  logic                    left_ins,
  input  logic [KEY_BITS-1:0]     left_key,
  input  logic [PAYLOAD_BITS-1:0] left_payload,
  input  logic [KEY_BITS-1:0]     right_key,
  input  logic [PAYLOAD_BITS-1:0] right_payload,
  output logic                    ins,
  output logic [KEY_BITS-1:0]     key_r,
  output logic [PAYLOAD_BITS-1:0] payload_r
);
  import spq_pkg::*;

  logic [KEY_BITS-1:0]     key_nxt;
  logic [PAYLOAD_BITS-1:0] payload_nxt;

  // new entry goes at or before this cell
  assign ins = !occupied || (new_key <= key_r);

  always_comb begin
    key_nxt     = key_r;
    payload_nxt = payload_r;
    if (ctrl.push && ins) begin
      if (left_ins) begin
        key_nxt     = left_key;
        payload_nxt = left_payload;
      end else begin
        key_nxt     = new_key;
        payload_nxt = new_payload;
      end
    end else if (ctrl.pop) begin
      key_nxt     = right_key;
      payload_nxt = right_payload;
    end
  end

  always_ff @(posedge clk) begin
    key_r     <= key_nxt;
    payload_r <= payload_nxt;
  end

endmodule

// ===== hdl/spq_checker.sv =====
module spq_checker #(
  parameter int unsigned KEY_BITS     = spq_pkg::KEY_BITS_DEF,
  parameter int unsigned PAYLOAD_BITS = spq_pkg::PAYLOAD_BITS_DEF,
  parameter int unsigned OUT_W        = ((KEY_BITS + PAYLOAD_BITS + 3 + 7) / 8) * 8
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata,
  input logic             out_tuser
);
  import spq_pkg::*;

  localparam int unsigned DROP_BIT  = KEY_BITS + PAYLOAD_BITS;
  localparam int unsigned EMPTY_BIT = DROP_BIT + 1;
  localparam int unsigned FULL_BIT  = DROP_BIT + 2;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  a_empty_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[EMPTY_BIT] && out_tdata[FULL_BIT]))
    else $error("empty and full both set");

  // a drop leaves the queue full, a successful pop never leaves it full
  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[DROP_BIT] |-> out_tdata[FULL_BIT] && !out_tuser)
    else $error("drop reported without full queue");

  a_pop_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> !out_tdata[FULL_BIT])
    else $error("full after pop");

  // every accepted word yields a result word in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("missing result word");

endmodule

bind sorted_priority_queue spq_checker #(
  .KEY_BITS     (KEY_BITS),
  .PAYLOAD_BITS (PAYLOAD_BITS),
  .OUT_W        (OUT_W)
) u_spq_checker (.*);
